// ===== design/cbis_pkg.sv =====
// ----------------------------------------------------------------------------
// Clamped bilinear image sampler package
// Shared types, register indexes, operation codes and small helper functions.
// ----------------------------------------------------------------------------
package cbis_pkg;

  // Positions and pixel indexes are handled in a 17-bit unsigned domain that
  // holds the integer part of a 16-bit position plus one, and any tile extent.
  localparam int POS_W = 17;
  typedef logic [POS_W-1:0] pos_t;

  typedef logic signed [15:0] pixel_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;
  localparam logic [1:0] CFG_FLOOR  = 2'd3;

  // Operation codes of an input item.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Sample modes.
  localparam logic MODE_BILINEAR = 1'b0;
  localparam logic MODE_NEAREST  = 1'b1;

  // Register reset values.
  localparam logic [8:0]   EXTENT_RESET        = 9'd256;
  localparam logic signed [15:0] NO_DATA_FLOOR_RESET = -16'sd1000;

  // Limits a programmed extent to the range [2, max_extent].
  function automatic pos_t sat_extent(logic [8:0] extent, pos_t max_extent);
    pos_t v;
    v = POS_W'(extent);
    if (v < POS_W'(2)) begin
      return POS_W'(2);
    end
    if (v > max_extent) begin
      return max_extent;
    end
    return v;
  endfunction

  // Clamps an index to the last valid one.
  function automatic pos_t clamp_idx(pos_t v, pos_t last);
    return (v > last) ? last : v;
  endfunction

endpackage

// ===== design/cbis_ram.sv =====
// ----------------------------------------------------------------------------
// Clamped bilinear image sampler RAM
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cbis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/clamped_bilinear_image_sampler.sv =====
// ----------------------------------------------------------------------------
// Clamped bilinear image sampler
// Holds one tile of signed 16-bit samples and returns bilinear or nearest
// samples at fixed-point positions as signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge where start is high and busy is low;
//   busy is always low. in_operation selects a pixel write (in_write_column,
//   in_write_row, in_pixel_value) or a sample (in_position_x, in_position_y,
//   unsigned with FRACTION_BITS fraction bits). A write gives no result. A
//   sample gives one result on out_elevation and out_no_data, marked by
//   out_valid for one cycle; the result passes the s1, s2 and s3 stage
//   registers and the output register. Results leave in order.
//   The receiver cannot stall, so the pipeline never holds back.
//   Throughput is one item per cycle: the tile store is split into four banks
//   by column and row parity, so the four neighbors of a position are read
//   in the same cycle. A write lands at its accepting edge, so a sample in
//   the next cycle already sees it.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
//   and must only be written while no sample is in flight.
//   Reset (rst_n low, synchronous) clears the pipeline and restores width 256,
//   height 256, bilinear mode and floor -1000. The tile store is not cleared;
//   a pixel must be written before it is read.
// ----------------------------------------------------------------------------
module clamped_bilinear_image_sampler
  import cbis_pkg::*;
#(
  parameter int IMAGE_WIDTH   = 256,
  parameter int IMAGE_HEIGHT  = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input item channel.
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [7:0]         in_write_column,
  input  logic [7:0]         in_write_row,
  input  logic signed [15:0] in_pixel_value,
  input  logic [15:0]        in_position_x,
  input  logic [15:0]        in_position_y,
  // Result channel.
  output logic               out_valid,
  output logic signed [31:0] out_elevation,
  output logic               out_no_data,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Each bank holds one column parity and one row parity of the tile.
  localparam int HALF_W     = (IMAGE_WIDTH + 1) / 2;
  localparam int HALF_H     = (IMAGE_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Fixed-point widths. Weights are products of two (F+1)-bit factors.
  localparam int F    = FRACTION_BITS;
  localparam int TOT  = 2 * F;
  localparam int WW   = TOT + 1;
  localparam int PW   = 16 + WW + 1;
  localparam int SUMW = PW + 2;

  localparam logic [F:0] ONE  = (F+1)'(1) << F;
  localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [8:0]   width_r;
  logic [8:0]   height_r;
  logic         mode_r;
  pixel_t       floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= EXTENT_RESET;
      height_r <= EXTENT_RESET;
      mode_r   <= MODE_BILINEAR;
      floor_r  <= NO_DATA_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[8:0];
        CFG_HEIGHT: height_r <= cfg_data[8:0];
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_FLOOR:  floor_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: index computation, clamping, bank addressing and weights.
  // --------------------------------------------------------------------------
  logic accept;
  logic is_sample;
  logic is_write;
  assign accept    = start && !busy;
  assign is_sample = accept && (in_operation == OP_SAMPLE);
  assign is_write  = accept && (in_operation == OP_WRITE);

  pos_t       last_col;
  pos_t       last_row;
  pos_t       ix;
  pos_t       iy;
  logic [F:0] fx_raw;
  logic [F:0] fy_raw;
  pos_t       nx;
  pos_t       ny;
  pos_t       col0;
  pos_t       col1;
  pos_t       row0;
  pos_t       row1;
  logic [F:0] fx;
  logic [F:0] fy;
  logic [F:0] gx;
  logic [F:0] gy;

  always_comb begin
    last_col = sat_extent(width_r, POS_W'(IMAGE_WIDTH)) - POS_W'(1);
    last_row = sat_extent(height_r, POS_W'(IMAGE_HEIGHT)) - POS_W'(1);

    ix     = POS_W'(in_position_x) >> F;
    iy     = POS_W'(in_position_y) >> F;
    fx_raw = (F+1)'(in_position_x & 16'((1 << F) - 1));
    fy_raw = (F+1)'(in_position_y & 16'((1 << F) - 1));

    // Round half to even for nearest mode.
    nx = ix;
    if (fx_raw > HALF || (fx_raw == HALF && ix[0])) begin
      nx = ix + POS_W'(1);
    end
    ny = iy;
    if (fy_raw > HALF || (fy_raw == HALF && iy[0])) begin
      ny = iy + POS_W'(1);
    end

    // Nearest mode is a bilinear fetch with all weight on one pixel.
    if (mode_r == MODE_NEAREST) begin
      col0 = clamp_idx(nx, last_col);
      col1 = col0;
      row0 = clamp_idx(ny, last_row);
      row1 = row0;
      fx   = '0;
      fy   = '0;
    end else begin
      col0 = clamp_idx(ix, last_col);
      col1 = clamp_idx(ix + POS_W'(1), last_col);
      row0 = clamp_idx(iy, last_row);
      row1 = clamp_idx(iy + POS_W'(1), last_row);
      fx   = fx_raw;
      fy   = fy_raw;
    end
    gx = ONE - fx;
    gy = ONE - fy;
  end

  // Write side: one pixel into the bank of its parity.
  logic                wr_in_range;
  logic [1:0]          wr_bank;
  logic [31:0]         wr_addr_full;
  logic [BANK_AW-1:0]  wr_addr;

  always_comb begin
    wr_in_range  = (32'(in_write_column) < 32'(IMAGE_WIDTH)) &&
                   (32'(in_write_row) < 32'(IMAGE_HEIGHT));
    wr_bank      = {in_write_row[0], in_write_column[0]};
    wr_addr_full = 32'(in_write_row >> 1) * 32'(HALF_W) + 32'(in_write_column >> 1);
    wr_addr      = wr_addr_full[BANK_AW-1:0];
  end

  // Four banks; bank index is {row parity, column parity}.
  pixel_t bank_rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pos_t               rd_col;
    pos_t               rd_row;
    logic [31:0]        rd_addr_full;
    logic [BANK_AW-1:0] rd_addr;
    logic               bank_we;

    always_comb begin
      rd_col       = (col0[0] == b[0]) ? col0 : col1;
      rd_row       = (row0[0] == b[1]) ? row0 : row1;
      rd_addr_full = 32'(rd_row >> 1) * 32'(HALF_W) + 32'(rd_col >> 1);
      rd_addr      = rd_addr_full[BANK_AW-1:0];
      bank_we      = is_write && wr_in_range && (wr_bank == 2'(b));
    end

    cbis_ram #(
      .WIDTH (16),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (wr_addr),
      .wdata (in_pixel_value),
      .raddr (rd_addr),
      .rdata (bank_rdata[b])
    );
  end

  // Stage 1 registers.
  logic          s1_valid_r;
  logic          s1_nearest_r;
  logic [1:0]    s1_sel_a_r;
  logic [1:0]    s1_sel_b_r;
  logic [1:0]    s1_sel_c_r;
  logic [1:0]    s1_sel_d_r;
  logic [WW-1:0] s1_wa_r;
  logic [WW-1:0] s1_wb_r;
  logic [WW-1:0] s1_wc_r;
  logic [WW-1:0] s1_wd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_sample;
    end
    s1_nearest_r <= (mode_r == MODE_NEAREST);
    s1_sel_a_r   <= {row0[0], col0[0]};
    s1_sel_b_r   <= {row0[0], col1[0]};
    s1_sel_c_r   <= {row1[0], col0[0]};
    s1_sel_d_r   <= {row1[0], col1[0]};
    s1_wa_r      <= WW'(gx) * WW'(gy);
    s1_wb_r      <= WW'(fx) * WW'(gy);
    s1_wc_r      <= WW'(gx) * WW'(fy);
    s1_wd_r      <= WW'(fx) * WW'(fy);
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick and weight the four neighbors, flag no data in nearest mode.
  // --------------------------------------------------------------------------
  pixel_t pix_a;
  pixel_t pix_b;
  pixel_t pix_c;
  pixel_t pix_d;

  assign pix_a = bank_rdata[s1_sel_a_r];
  assign pix_b = bank_rdata[s1_sel_b_r];
  assign pix_c = bank_rdata[s1_sel_c_r];
  assign pix_d = bank_rdata[s1_sel_d_r];

  logic                 s2_valid_r;
  logic                 s2_no_data_r;
  logic signed [PW-1:0] s2_pa_r;
  logic signed [PW-1:0] s2_pb_r;
  logic signed [PW-1:0] s2_pc_r;
  logic signed [PW-1:0] s2_pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_no_data_r <= s1_nearest_r && (pix_a < floor_r);
    s2_pa_r      <= PW'(pix_a) * PW'(signed'({1'b0, s1_wa_r}));
    s2_pb_r      <= PW'(pix_b) * PW'(signed'({1'b0, s1_wb_r}));
    s2_pc_r      <= PW'(pix_c) * PW'(signed'({1'b0, s1_wc_r}));
    s2_pd_r      <= PW'(pix_d) * PW'(signed'({1'b0, s1_wd_r}));
  end

  // --------------------------------------------------------------------------
  // Stage 2: sum of the weighted neighbors.
  // --------------------------------------------------------------------------
  logic                   s3_valid_r;
  logic                   s3_no_data_r;
  logic signed [SUMW-1:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_no_data_r <= s2_no_data_r;
    s3_sum_r     <= SUMW'(s2_pa_r) + SUMW'(s2_pb_r) + SUMW'(s2_pc_r) + SUMW'(s2_pd_r);
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale the sum to Q16.16, zero it for no data, and register the result.
  // --------------------------------------------------------------------------
  logic [31:0] elev_nxt;

  if (TOT <= 16) begin : g_exact
    // The sum is exact in units of 2^-TOT; widen and shift up.
    logic signed [SUMW+15:0] sum_ext;
    logic signed [SUMW+15:0] sum_shl;
    assign sum_ext  = (SUMW+16)'(s3_sum_r);
    assign sum_shl  = sum_ext <<< (16 - TOT);
    assign elev_nxt = sum_shl[31:0];
  end else begin : g_round
    // Drop the extra fraction bits, rounding half toward plus infinity.
    localparam int SH = TOT - 16;
    localparam logic signed [SUMW:0] RND = (SUMW+1)'(1) <<< (SH - 1);
    logic signed [SUMW:0] sum_rnd;
    logic signed [SUMW:0] sum_shr;
    assign sum_rnd  = (SUMW+1)'(s3_sum_r) + RND;
    assign sum_shr  = sum_rnd >>> SH;
    assign elev_nxt = sum_shr[31:0];
  end

  logic        out_valid_r;
  logic [31:0] out_elevation_r;
  logic        out_no_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
    out_elevation_r <= s3_no_data_r ? 32'd0 : elev_nxt;
    out_no_data_r   <= s3_no_data_r;
  end

  assign out_valid     = out_valid_r;
  assign out_elevation = out_elevation_r;
  assign out_no_data   = out_no_data_r;

endmodule
